>>> rtl/assert_macros.svh
// Assertion macros shared by the RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("check failed");
// Next-cycle implication.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("check failed");
`endif

>>> rtl/smie_pkg.sv
// Package: opcodes, status codes and sizes of the stack machine executor.
`timescale 1ns / 1ps
package smie_pkg;
	localparam int STACK_DEPTH_DEF = 64;
	localparam int REG_COUNT_DEF   = 4;
	localparam int CODE_WORDS_DEF  = 1024;

	typedef enum logic [3:0] {
		OP_PUSH = 4'd0, OP_POP = 4'd1, OP_ADD = 4'd2, OP_SUB = 4'd3,
		OP_MUL = 4'd4, OP_DIV = 4'd5, OP_JMP = 4'd6, OP_JA = 4'd7,
		OP_JB = 4'd8, OP_JE = 4'd9, OP_JAE = 4'd10, OP_JBE = 4'd11,
		OP_JNE = 4'd12, OP_OUT = 4'd13, OP_HLT = 4'd14, OP_BAD = 4'd15
	} op_t;

	typedef enum logic [2:0] {
		ST_OK = 3'd0, ST_HALT = 3'd1, ST_BADOP = 3'd2, ST_UNDER = 3'd3,
		ST_OVER = 3'd4, ST_DIVZ = 3'd5
	} status_t;

	// Shared ALU function select.
	typedef enum logic [1:0] {
		ALU_ADD = 2'd0, ALU_SUB = 2'd1, ALU_MUL = 2'd2
	} alu_op_t;

	typedef struct packed {
		logic    start;
		alu_op_t op;
	} alu_ctl_t;
endpackage

>>> rtl/smie_alu.sv
// Shared arithmetic unit: one registered add, subtract or multiply per request.
`timescale 1ns / 1ps
module smie_alu
	import smie_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  alu_ctl_t    ctl,
	input  logic [31:0] a,
	input  logic [31:0] b,
	output logic [31:0] result,
	output logic        done
);
	logic [31:0] res_q;
	logic        done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= ctl.start;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			unique case (ctl.op)
				ALU_ADD: res_q <= a + b;
				ALU_SUB: res_q <= a - b;
				ALU_MUL: res_q <= a * b;
				default: res_q <= a - b;
			endcase
		end
	end

	assign result = res_q;
	assign done   = done_q;
endmodule

>>> rtl/smie_div.sv
// Signed 32-bit divider, one quotient bit a cycle, truncating toward zero.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module smie_div
	import smie_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic [31:0] dividend,
	input  logic [31:0] divisor,
	output logic [31:0] quotient,
	output logic        done
);
	logic [31:0] rem_q, quo_q, dsr_q;
	logic [5:0]  cnt_q;
	logic        busy_q, neg_q, done_q;
	logic [32:0] trial;
	logic [31:0] shifted;

	assign shifted = {rem_q[30:0], quo_q[31]};
	assign trial   = {1'b0, shifted} - {1'b0, dsr_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= 6'd32;
			end else if (busy_q) begin
				cnt_q <= cnt_q - 6'd1;
				if (cnt_q == 6'd1) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend[31] ? (~dividend + 32'd1) : dividend;
			dsr_q <= divisor[31] ? (~divisor + 32'd1) : divisor;
			neg_q <= dividend[31] ^ divisor[31];
		end else if (busy_q) begin
			if (!trial[32]) begin
				rem_q <= trial[31:0];
				quo_q <= {quo_q[30:0], 1'b1};
			end else begin
				rem_q <= shifted;
				quo_q <= {quo_q[30:0], 1'b0};
			end
		end
	end

	assign quotient = neg_q ? (~quo_q + 32'd1) : quo_q;
	assign done     = done_q;

	`CHK_NEXT(a_div_done_once, clk, arst_n, done_q, !done_q)
	`CHK_IMPL(a_div_no_restart, clk, arst_n, busy_q, !start)
	`CHK_NEXT(a_div_start_busy, clk, arst_n, start, busy_q)
endmodule

>>> rtl/stack_machine_instruction_executor_core.sv
// Top level: sequenced stack machine executor with stack memory and shared units.
// Usage:
//  s_axis carries one decoded instruction per transfer; tdata packs, from bit 0:
//  mode[3:0], arg_kind[5:4], immediate[37:6], reg_index[39:38], jump_target[49:40].
//  m_axis returns one result per instruction; tdata packs, from bit 0:
//  next_address[9:0], out_valid[10], out_value[42:11], status[45:43].
//  States from the input transfer to the output register, by instruction:
//  push, jmp, hlt, bad opcode and any instruction while halted: S_RD1, S_OUT;
//  pop/out and their underflow: S_RD1, S_RD2 (one registered stack read), S_OUT;
//  compares, other underflow and divide by zero: S_RD1, S_RD2, S_EXEC (two
//  reads, then decide), S_OUT; add/sub/mul/div: then S_WAIT (shared ALU or
//  32-step divider) and S_WB (write-back) before S_OUT. The sequencer, the
//  single stack memory port and the shared ALU/divider set this order;
//  s_axis_tready is high only in S_IDLE, after the last instruction's S_OUT.
//  Reset clears the stack count, registers, program counter and halt flag;
//  stack memory contents are not cleared and need no pass.
//  A result is held in the output register while m_axis_tready is low; the
//  next instruction may still be taken and run, and its result waits in the
//  sequencer until the output register frees up.
`timescale 1ns / 1ps
`include "assert_macros.svh"
module stack_machine_instruction_executor_core
	import smie_pkg::*;
#(
	parameter int STACK_DEPTH = STACK_DEPTH_DEF,
	parameter int REG_COUNT   = REG_COUNT_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// mode, arg_kind, immediate, reg_index, jump_target (from bit 0)
	input  logic [55:0] s_axis_tdata,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// next_address, out_valid, out_value, status (from bit 0)
	output logic [47:0] m_axis_tdata
);
	localparam int SAW = $clog2(STACK_DEPTH);
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	localparam int RIW = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
	localparam logic [SCW-1:0] FULL = SCW'(STACK_DEPTH);

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_RD1   = 7'b0000010,
		S_RD2   = 7'b0000100,
		S_EXEC  = 7'b0001000,
		S_WAIT  = 7'b0010000,
		S_WB    = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q;

	// Instruction fields held for the whole sequence.
	op_t         mode_q;
	logic [1:0]  kind_q;
	logic [31:0] imm_q;
	logic [1:0]  reg_q;
	logic [9:0]  tgt_q;

	logic [SCW-1:0] cnt_q;
	logic [31:0]    regs_q [REG_COUNT];
	logic [9:0]     pc_q;
	logic           halt_q;

	// Stack memory, one port, registered read.
	logic [31:0] mem [STACK_DEPTH];
	logic [31:0] rd_data;
	logic        mem_we;
	logic [SAW-1:0] mem_addr;
	logic [31:0] mem_wdata;
	logic [31:0] top_q;
	logic [31:0] sec_val;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_addr] <= mem_wdata;
		end
		rd_data <= mem[mem_addr];
	end

	// Second entry comes out of the memory in S_EXEC, in the cycle after its
	// read in S_RD2; the shared units sample it at their start.
	assign sec_val = rd_data;

	// Working result, built up while the instruction runs.
	logic        ov_q;
	logic [9:0]  na_q;
	logic        outv_q;
	logic [31:0] outval_q;
	status_t     st_q;

	// Output register, loaded once the working result is complete.
	logic [47:0] mdata_q;
	logic        out_load;

	alu_ctl_t    alu_ctl;
	logic [31:0] alu_res, div_res;
	logic        alu_done, div_done, div_start;

	smie_alu u_alu (
		.clk(clk), .arst_n(arst_n), .ctl(alu_ctl), .a(sec_val), .b(top_q),
		.result(alu_res), .done(alu_done)
	);

	smie_div u_div (
		.clk(clk), .arst_n(arst_n), .start(div_start), .dividend(sec_val),
		.divisor(top_q), .quotient(div_res), .done(div_done)
	);

	// Code addresses wrap at 1024 words, the width of the address fields.
	function automatic logic [9:0] pc_add(input logic [9:0] pc, input logic [1:0] n);
		return pc + {8'd0, n};
	endfunction

	logic accept;
	assign accept        = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == S_IDLE);
	assign m_axis_tvalid = ov_q;
	assign m_axis_tdata  = mdata_q;
	assign out_load      = (state_q == S_OUT) && (!ov_q || m_axis_tready);

	logic binop, cjump, enough2;
	assign binop   = (mode_q == OP_ADD) || (mode_q == OP_SUB) ||
		(mode_q == OP_MUL) || (mode_q == OP_DIV);
	assign cjump   = (mode_q >= OP_JA) && (mode_q <= OP_JNE);
	assign enough2 = (cnt_q >= SCW'(2)) && (cnt_q <= FULL);

	logic take;
	logic signed [31:0] ts, ss;
	assign ts = top_q;
	assign ss = sec_val;
	always_comb begin
		unique case (mode_q)
			OP_JA:   take = ts < ss;
			OP_JB:   take = ts > ss;
			OP_JE:   take = ts == ss;
			OP_JAE:  take = ts <= ss;
			OP_JBE:  take = ts >= ss;
			default: take = ts != ss;
		endcase
	end

	logic [31:0] push_val;
	always_comb begin
		push_val = '0;
		if (kind_q[0]) begin
			push_val = imm_q;
		end else if (kind_q[1] && (32'(reg_q) < 32'(REG_COUNT))) begin
			push_val = regs_q[RIW'(reg_q)];
		end
	end

	// Next address and status known right after decode.
	logic [9:0] rd1_na;
	status_t    rd1_st;
	always_comb begin
		rd1_na = pc_add(pc_q, 2'd1);
		rd1_st = ST_OK;
		if (halt_q) begin
			rd1_st = ST_HALT;
			rd1_na = pc_q;
		end else begin
			unique case (mode_q)
				OP_PUSH: begin
					rd1_na = pc_add(pc_q, (kind_q == 2'b00) ? 2'd2 : 2'd3);
					if (cnt_q >= FULL) rd1_st = ST_OVER;
				end
				OP_POP: rd1_na = pc_add(pc_q, 2'd3);
				OP_JMP: rd1_na = tgt_q;
				OP_HLT: begin
					rd1_st = ST_HALT;
					rd1_na = pc_q;
				end
				OP_BAD: rd1_st = ST_BADOP;
				OP_JA, OP_JB, OP_JE, OP_JAE, OP_JBE, OP_JNE:
					rd1_na = pc_add(pc_q, 2'd2);
				default: ;
			endcase
		end
	end

	// Memory address and write control, and the start of the shared units.
	always_comb begin
		mem_we    = 1'b0;
		mem_wdata = push_val;
		mem_addr  = SAW'(cnt_q - SCW'(1));
		alu_ctl   = '{start: 1'b0, op: ALU_ADD};
		div_start = 1'b0;
		unique case (state_q)
			S_RD1: begin
				if (mode_q == OP_PUSH) begin
					mem_addr = SAW'(cnt_q);
					mem_we   = !halt_q && (cnt_q < FULL);
				end
			end
			S_RD2: mem_addr = SAW'(cnt_q - SCW'(2));
			S_EXEC: begin
				if (binop && enough2) begin
					if (mode_q == OP_DIV) begin
						div_start = (top_q != '0);
					end else begin
						alu_ctl.start = 1'b1;
						alu_ctl.op = (mode_q == OP_ADD) ? ALU_ADD :
							(mode_q == OP_SUB) ? ALU_SUB : ALU_MUL;
					end
				end
			end
			S_WB: begin
				mem_addr  = SAW'(cnt_q - SCW'(2));
				mem_wdata = (mode_q == OP_DIV) ? div_res : alu_res;
				mem_we    = 1'b1;
			end
			default: ;
		endcase
	end

	// Sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
			pc_q    <= '0;
			halt_q  <= 1'b0;
			ov_q    <= 1'b0;
			for (int i = 0; i < REG_COUNT; i++) begin
				regs_q[i] <= '0;
			end
		end else begin
			// Advance the output register: load a new result or drop the sent one.
			if (out_load) begin
				ov_q <= 1'b1;
			end else if (ov_q && m_axis_tready) begin
				ov_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RD1;
					end
				end
				S_RD1: begin
					if (halt_q || mode_q == OP_PUSH || mode_q == OP_JMP ||
							mode_q == OP_HLT || mode_q == OP_BAD) begin
						state_q <= S_OUT;
						if (!halt_q && mode_q == OP_PUSH && cnt_q < FULL) begin
							cnt_q <= cnt_q + SCW'(1);
						end
						if (!halt_q && mode_q == OP_HLT) begin
							halt_q <= 1'b1;
						end
					end else begin
						state_q <= S_RD2;
					end
				end
				S_RD2: begin
					// rd_data now holds the top entry
					if ((mode_q == OP_POP || mode_q == OP_OUT)) begin
						state_q <= S_OUT;
						if (cnt_q != '0) begin
							cnt_q <= cnt_q - SCW'(1);
							if (mode_q == OP_POP && 32'(reg_q) < 32'(REG_COUNT)) begin
								regs_q[RIW'(reg_q)] <= rd_data;
							end
						end
					end else begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					if (binop && enough2 && !(mode_q == OP_DIV && top_q == '0)) begin
						state_q <= S_WAIT;
					end else begin
						state_q <= S_OUT;
						if (cjump && enough2) begin
							cnt_q <= cnt_q - SCW'(2);
						end
					end
				end
				S_WAIT: begin
					if (alu_done || div_done) begin
						state_q <= S_WB;
					end
				end
				S_WB: begin
					cnt_q   <= cnt_q - SCW'(1);
					state_q <= S_OUT;
				end
				S_OUT: begin
					// Hold here until the output register can take the result.
					if (out_load) begin
						pc_q    <= na_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q <= op_t'(s_axis_tdata[3:0]);
			kind_q <= s_axis_tdata[5:4];
			imm_q  <= s_axis_tdata[37:6];
			reg_q  <= s_axis_tdata[39:38];
			tgt_q  <= s_axis_tdata[49:40];
		end
		if (state_q == S_RD2) begin
			top_q <= rd_data;
		end
		if (out_load) begin
			mdata_q <= {2'b00, st_q, outval_q, outv_q, na_q};
		end
		unique case (state_q)
			S_RD1: begin
				outv_q   <= 1'b0;
				outval_q <= '0;
				st_q     <= rd1_st;
				na_q     <= rd1_na;
			end
			S_RD2: begin
				if (mode_q == OP_POP || mode_q == OP_OUT) begin
					if (cnt_q == '0) begin
						st_q <= ST_UNDER;
					end else if (mode_q == OP_OUT) begin
						outv_q   <= 1'b1;
						outval_q <= rd_data;
					end
				end
			end
			S_EXEC: begin
				if (!enough2) begin
					st_q <= ST_UNDER;
				end else if (mode_q == OP_DIV && top_q == '0) begin
					st_q <= ST_DIVZ;
				end else if (cjump && take) begin
					na_q <= tgt_q;
				end
			end
			default: ;
		endcase
	end

	`CHK_IMPL(a_ready_idle, clk, arst_n, s_axis_tready, state_q == S_IDLE)
	`CHK_IMPL(a_count_range, clk, arst_n, 1'b1, cnt_q <= FULL)
	`CHK_NEXT(a_halt_sticky, clk, arst_n, halt_q, halt_q)
	`CHK_NEXT(a_out_hold, clk, arst_n, ov_q && !m_axis_tready, ov_q)
endmodule
